FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used in the receiver RTL (stx_back).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/stx_pkg.sv
// ----------------------------------------------------------------------------
// stx_pkg
// Types and constants shared by the block receiver modules.
// ----------------------------------------------------------------------------
package stx_pkg;

    localparam int CFG_W     = 21;
    localparam int CFG_IDX_W = 2;
    localparam int TOTAL_W   = 21;
    localparam int LEN_W     = 16;
    localparam int QUEUE_AW  = 2;
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY    = 2'd2;

    localparam logic [CFG_W-1:0] CAPACITY_RESET = 21'h100000;
    localparam logic [7:0]       RETRY_RESET    = 8'd10;

    // Input command codes.
    localparam logic [1:0] CMD_START    = 2'd0;
    localparam logic [1:0] CMD_BYTE     = 2'd1;
    localparam logic [1:0] CMD_LINE_ERR = 2'd2;

    // Line control characters.
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_DC2 = 8'h12;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_ETB = 8'h17;

    // Status codes.
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_RUN      = 3'd1;
    localparam logic [2:0] ST_DONE     = 3'd2;
    localparam logic [2:0] ST_RETRY    = 3'd3;
    localparam logic [2:0] ST_OVERSIZE = 3'd4;
    localparam logic [2:0] ST_MISMATCH = 3'd5;

    typedef enum logic [1:0] {
        K_START,
        K_BYTE,
        K_LINE_ERR,
        K_NONE
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [CFG_W-1:0] capacity;
        logic [CFG_W-1:0] expected;
        logic [7:0]       retry_limit;
    } t_cfg;

endpackage

FILE: rtl/stx_in_if.sv
// ----------------------------------------------------------------------------
// stx_in_if
// Input channel: command and received byte with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface stx_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

FILE: rtl/stx_res_if.sv
// ----------------------------------------------------------------------------
// stx_res_if
// Result channel: control byte, payload write and status per transfer.
// ----------------------------------------------------------------------------
interface stx_res_if #(
    parameter int ADDR_BITS = 20
);
    logic                 valid;
    logic                 ready;
    logic                 tx_valid;
    logic [7:0]           tx_byte;
    logic                 mem_write;
    logic [ADDR_BITS-1:0] mem_addr;
    logic [7:0]           mem_data;
    logic [2:0]           status;
    logic [20:0]          total_bytes;

    modport source (output valid, output tx_valid, output tx_byte, output mem_write,
                    output mem_addr, output mem_data, output status,
                    output total_bytes, input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input mem_write,
                    input mem_addr, input mem_data, input status,
                    input total_bytes, output ready);
endinterface

FILE: rtl/stx_block_receiver.sv
// ----------------------------------------------------------------------------
// stx_block_receiver
// Receiver for STX/ETB/ETX framed blocks with an additive check byte.
// ----------------------------------------------------------------------------
// The receiver takes one command per input transfer (start, received byte,
// or line error) and returns exactly one result transfer per command, in
// order, carrying the control byte to send back (DC2, ACK or NAK), an
// optional payload write with its running buffer address, the transfer
// status and the running byte total. It sustains one command per clock
// while results are taken: a front register classifies the command, a
// four-entry queue decouples it from the back sequencer, and the sequencer
// updates the framing state once per item and loads a result register, so
// a command passes the front register, the queue and the result register
// before its result is presented. Either side may stall on its own without
// loss; input is taken while a result waits to be collected until the queue
// fills. Configuration registers are written through the plain write port
// and should only be changed while the block holds no command in flight.
// ----------------------------------------------------------------------------
module stx_block_receiver #(
    parameter int ADDR_BITS = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    stx_in_if.sink                          i_rx,
    stx_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [stx_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [stx_pkg::CFG_W-1:0]       i_cfg_data
);
    import stx_pkg::*;

    // Configuration registers. Writes to an index beyond the list are dropped.
    t_cfg  r_cfg;

    // Front to queue, queue to back.
    logic  front_valid;
    t_item front_item;
    logic  queue_ready;
    logic  queue_valid;
    t_item queue_item;
    logic  back_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity    <= CAPACITY_RESET;
            r_cfg.expected    <= '0;
            r_cfg.retry_limit <= RETRY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CAPACITY: r_cfg.capacity    <= i_cfg_data;
                REG_EXPECTED: r_cfg.expected    <= i_cfg_data;
                REG_RETRY:    r_cfg.retry_limit <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    stx_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .o_item_valid (front_valid),
        .o_item       (front_item),
        .i_item_ready (queue_ready)
    );

    stx_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_item  (front_item),
        .o_push_ready (queue_ready),
        .o_pop_valid  (queue_valid),
        .o_pop_item   (queue_item),
        .i_pop        (back_pop)
    );

    stx_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (queue_valid),
        .i_item       (queue_item),
        .o_pop        (back_pop),
        .o_res        (o_res)
    );

endmodule

FILE: rtl/stx_front.sv
// ----------------------------------------------------------------------------
// stx_front
// Accepts input transfers and classifies each command into an item kind.
// ----------------------------------------------------------------------------
module stx_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    stx_in_if.sink         i_rx,
    output logic           o_item_valid,
    output stx_pkg::t_item o_item,
    input  logic           i_item_ready
);
    import stx_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign i_rx.ready   = !r_valid || i_item_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        n_item.data = i_rx.rx_byte;
        unique case (i_rx.command)
            CMD_START:    n_item.kind = K_START;
            CMD_BYTE:     n_item.kind = K_BYTE;
            CMD_LINE_ERR: n_item.kind = K_LINE_ERR;
            default:      n_item.kind = K_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
        if (i_rx.valid && i_rx.ready) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: rtl/stx_queue.sv
// ----------------------------------------------------------------------------
// stx_queue
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module stx_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  stx_pkg::t_item i_push_item,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output stx_pkg::t_item o_pop_item,
    input  logic           i_pop
);
    import stx_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = r_count != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_item   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
        end
        if (push) begin
            r_mem[r_wp] <= i_push_item;
        end
    end

endmodule

FILE: rtl/stx_back.sv
// ----------------------------------------------------------------------------
// stx_back
// Block framing sequencer: one item per cycle unless stalled; holds the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stx_back #(
    parameter int ADDR_BITS = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  stx_pkg::t_cfg  i_cfg,
    input  logic           i_item_valid,
    input  stx_pkg::t_item i_item,
    output logic           o_pop,
    stx_res_if.source      o_res
);
    import stx_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_STX,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DATA,
        PH_TERM,
        PH_CHECK,
        PH_ENDED
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [7:0]         r_hdr, n_hdr;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_cnt, n_cnt;
    logic [7:0]         r_sum, n_sum;
    logic [7:0]         r_term, n_term;
    logic [TOTAL_W-1:0] r_acc, n_acc;
    logic [7:0]         r_att, n_att;
    logic [2:0]         r_end, n_end;
    logic [TOTAL_W-1:0] r_room, r_left;

    logic                 r_out_valid;
    logic                 r_res_txv, n_res_txv;
    logic [7:0]           r_res_txb, n_res_txb;
    logic                 r_res_mw, n_res_mw;
    logic [ADDR_BITS-1:0] r_res_addr, n_res_addr;
    logic [7:0]           r_res_data, n_res_data;
    logic [2:0]           r_res_status, n_res_status;

    logic                   pop;
    logic                   running;
    logic                   nak_retry;
    logic [7:0]             att_inc;
    logic [LEN_W-1:0]       len_lo;
    logic [LEN_W-1:0]       cnt_inc;
    logic [TOTAL_W:0]       acc_sum;
    logic [TOTAL_W:0]       addr_sum;
    logic [ADDR_BITS+TOTAL_W:0] addr_ext;

    assign pop   = i_item_valid && (!r_out_valid || o_res.ready);
    assign o_pop = pop;

    assign o_res.valid       = r_out_valid;
    assign o_res.tx_valid    = r_res_txv;
    assign o_res.tx_byte     = r_res_txb;
    assign o_res.mem_write   = r_res_mw;
    assign o_res.mem_addr    = r_res_addr;
    assign o_res.mem_data    = r_res_data;
    assign o_res.status      = r_res_status;
    assign o_res.total_bytes = r_acc;

    assign running  = (r_phase != PH_IDLE) && (r_phase != PH_ENDED);
    assign att_inc  = r_att + 8'd1;
    assign len_lo   = {r_len[LEN_W-1:8], i_item.data};
    assign cnt_inc  = r_cnt + 1'b1;
    assign acc_sum  = {1'b0, r_acc} + (TOTAL_W+1)'(r_len);
    assign addr_sum = {1'b0, r_acc} + (TOTAL_W+1)'(r_cnt);
    assign addr_ext = {{ADDR_BITS{1'b0}}, addr_sum};

    always_comb begin
        n_phase    = r_phase;
        n_hdr      = r_hdr;
        n_len      = r_len;
        n_cnt      = r_cnt;
        n_sum      = r_sum;
        n_term     = r_term;
        n_acc      = r_acc;
        n_att      = r_att;
        n_end      = r_end;
        n_res_txv  = 1'b0;
        n_res_txb  = '0;
        n_res_mw   = 1'b0;
        n_res_addr = '0;
        n_res_data = '0;
        nak_retry  = 1'b0;

        case (i_item.kind)
            K_START: begin
                n_acc  = '0;
                n_att  = '0;
                n_hdr  = '0;
                n_len  = '0;
                n_cnt  = '0;
                n_sum  = '0;
                n_term = '0;
                if (i_cfg.expected != '0 && i_cfg.expected > i_cfg.capacity) begin
                    n_phase = PH_ENDED;
                    n_end   = ST_OVERSIZE;
                end else begin
                    n_res_txv = 1'b1;
                    n_res_txb = CH_DC2;
                    n_phase   = PH_STX;
                end
            end
            K_LINE_ERR: begin
                nak_retry = running;
            end
            K_BYTE: begin
                case (r_phase)
                    PH_STX: begin
                        n_hdr   = i_item.data;
                        n_sum   = '0;
                        n_phase = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        n_len   = {i_item.data, 8'h00};
                        n_sum   = i_item.data;
                        n_phase = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_len = len_lo;
                        n_sum = r_sum + i_item.data;
                        n_cnt = '0;
                        if (r_hdr != CH_STX) begin
                            nak_retry = 1'b1;
                        end else if (TOTAL_W'(len_lo) > r_room ||
                                     (i_cfg.expected != '0 && TOTAL_W'(len_lo) > r_left)) begin
                            n_res_txv = 1'b1;
                            n_res_txb = CH_NAK;
                            n_phase   = PH_ENDED;
                            n_end     = ST_OVERSIZE;
                        end else begin
                            n_phase = (len_lo == '0) ? PH_TERM : PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        n_res_mw   = 1'b1;
                        n_res_addr = addr_ext[ADDR_BITS-1:0];
                        n_res_data = i_item.data;
                        n_sum      = r_sum + i_item.data;
                        n_cnt      = cnt_inc;
                        if (cnt_inc >= r_len) begin
                            n_phase = PH_TERM;
                        end
                    end
                    PH_TERM: begin
                        n_term  = i_item.data;
                        n_sum   = r_sum + i_item.data;
                        n_phase = PH_CHECK;
                    end
                    PH_CHECK: begin
                        if (r_sum != ~i_item.data ||
                            (r_term != CH_ETX && r_term != CH_ETB)) begin
                            nak_retry = 1'b1;
                        end else if (r_term == CH_ETX && i_cfg.expected != '0 &&
                                     acc_sum != {1'b0, i_cfg.expected}) begin
                            n_res_txv = 1'b1;
                            n_res_txb = CH_NAK;
                            n_phase   = PH_ENDED;
                            n_end     = ST_MISMATCH;
                        end else begin
                            n_acc     = acc_sum[TOTAL_W-1:0];
                            n_res_txv = 1'b1;
                            n_res_txb = CH_ACK;
                            n_att     = '0;
                            if (r_term == CH_ETX) begin
                                n_phase = PH_ENDED;
                                n_end   = ST_DONE;
                            end else begin
                                n_phase = PH_STX;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        // A NAKed attempt counts toward the retry limit for this block.
        if (nak_retry) begin
            n_res_txv = 1'b1;
            n_res_txb = CH_NAK;
            n_att     = att_inc;
            if (att_inc >= i_cfg.retry_limit) begin
                n_phase = PH_ENDED;
                n_end   = ST_RETRY;
            end else begin
                n_phase = PH_STX;
            end
        end

        if (n_phase == PH_IDLE) begin
            n_res_status = ST_IDLE;
        end else if (n_phase == PH_ENDED) begin
            n_res_status = n_end;
        end else begin
            n_res_status = ST_RUN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_hdr       <= '0;
            r_len       <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_term      <= '0;
            r_acc       <= '0;
            r_att       <= '0;
            r_end       <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_phase <= n_phase;
                r_hdr   <= n_hdr;
                r_len   <= n_len;
                r_cnt   <= n_cnt;
                r_sum   <= n_sum;
                r_term  <= n_term;
                r_acc   <= n_acc;
                r_att   <= n_att;
                r_end   <= n_end;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (pop) begin
            r_res_txv    <= n_res_txv;
            r_res_txb    <= n_res_txb;
            r_res_mw     <= n_res_mw;
            r_res_addr   <= n_res_addr;
            r_res_data   <= n_res_data;
            r_res_status <= n_res_status;
        end
        // Room and remaining expected bytes are registered from the running total;
        // the length check comes at least three items after any change to it.
        r_room <= (i_cfg.capacity > r_acc) ? i_cfg.capacity - r_acc : '0;
        r_left <= (i_cfg.expected > r_acc) ? i_cfg.expected - r_acc : '0;
    end

    `AST_IMPLY(a_write_not_ctrl, i_clk, i_rst_n, r_out_valid && r_res_mw, !r_res_txv, "payload write with control byte")
    `AST_IMPLY(a_cnt_below_len, i_clk, i_rst_n, r_phase == PH_DATA, r_cnt < r_len, "data count past block length")
    `AST_NEXT(a_acc_hold, i_clk, i_rst_n, !pop, $stable(r_acc), "byte total moved without an item")
    `AST_IMPLY(a_write_in_data, i_clk, i_rst_n, pop && n_res_mw, r_phase == PH_DATA, "payload write outside data phase")

endmodule
